>>> rtl/chap_pkg.sv
// shared types, codes and constants of the chacha20-poly1305 aead core
package chap_pkg;

  // item mode codes
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_AAD    = 2'd1;
  localparam logic [1:0] MODE_PAY    = 2'd2;
  localparam logic [1:0] MODE_FINISH = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_AUTH = 2'd1;
  localparam logic [1:0] STAT_SEQ  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_NONCE_L = 3'd4;
  localparam logic [2:0] REG_NONCE_H = 3'd5;
  localparam logic [2:0] REG_OPEN    = 3'd6;

  // chacha constants and poly1305 clamp
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [127:0] CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  byte_count;
  } item_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic [4:0]  result_count;
    logic [1:0]  status;
  } res_t;

  // classified item as queued between front and back
  typedef struct packed {
    logic [1:0]   mode;
    logic [127:0] dat;
    logic [127:0] raw;
    logic [127:0] bmask;
    logic [4:0]   n;
    logic         too_long;
    logic         empty;
  } citem_t;

  typedef enum logic [1:0] {PH_IDLE, PH_AAD, PH_PAY} phase_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_KEY, ST_KS, ST_CRYPT, ST_MAC, ST_TAG, ST_RES
  } st_e;

  typedef enum logic [1:0] {POLY_CLEAR, POLY_BLOCK, POLY_TAG} poly_op_e;

  typedef enum logic [3:0] {
    PS_IDLE, PS_MUL, PS_ADD, PS_RED1, PS_RED2, PS_TAG2, PS_TAG3, PS_TAG4
  } poly_st_e;

  typedef struct packed {
    logic         start;
    poly_op_e     op;
    logic [127:0] m;
    logic [127:0] s;
  } poly_cmd_t;

  typedef struct packed {
    logic         done;
    logic [127:0] tag;
  } poly_stat_t;

  // byte b of the mask is set when b lies below n
  function automatic logic [127:0] byte_mask(input logic [4:0] n);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < 16; b++) begin
      m[8*b +: 8] = (5'(b) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

>>> rtl/chacha20_poly1305_aead_core.sv
// chacha20-poly1305 aead core: registers, sequencer and result register
//
// Words enter on the input channel (in_valid_i / in_stall_o) and each gives
// exactly one result word on the output channel (out_valid_o / out_stall_i),
// in order. Key, nonce and open_mode are written through the apb port; they
// must only change while the core is idle.
// A two-entry queue at the input lets the sender run ahead while the back
// end works; the result register lets the next word start while a result
// waits for the receiver. A stalled receiver holds the result and, once the
// queue is full, stalls the sender.
// A start runs 20 chacha half rounds plus load and sum. An aad or payload
// chunk runs 20 poly1305 32x32 partial products and two folds; the first
// and then every fourth non-empty payload chunk first refill the keystream.
// A finish also forms the tag; sequence errors and empty chunks skip the units.
// Reset clears the configuration registers, the queue pointers and the message
// phase, lengths and flags; the block counter is one and the keystream is marked empty.
module chacha20_poly1305_aead_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  chap_pkg::item_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output chap_pkg::res_t   out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  // configuration registers
  logic [63:0] key_q [4];
  logic [63:0] nonce_low_q;
  logic [31:0] nonce_high_q;
  logic        open_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      nonce_low_q  <= '0;
      nonce_high_q <= '0;
      open_q       <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[5:3])
        chap_pkg::REG_KEY0:    key_q[0] <= pwdata;
        chap_pkg::REG_KEY1:    key_q[1] <= pwdata;
        chap_pkg::REG_KEY2:    key_q[2] <= pwdata;
        chap_pkg::REG_KEY3:    key_q[3] <= pwdata;
        chap_pkg::REG_NONCE_L: nonce_low_q <= pwdata;
        chap_pkg::REG_NONCE_H: nonce_high_q <= pwdata[31:0];
        chap_pkg::REG_OPEN:    open_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[5:3])
      chap_pkg::REG_KEY0:    prdata = key_q[0];
      chap_pkg::REG_KEY1:    prdata = key_q[1];
      chap_pkg::REG_KEY2:    prdata = key_q[2];
      chap_pkg::REG_KEY3:    prdata = key_q[3];
      chap_pkg::REG_NONCE_L: prdata = nonce_low_q;
      chap_pkg::REG_NONCE_H: prdata = {32'b0, nonce_high_q};
      chap_pkg::REG_OPEN:    prdata = {63'b0, open_q};
      default:               prdata = '0;
    endcase
  end

  // front queue
  logic             pop, head_valid;
  chap_pkg::citem_t head;

  chap_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .pop_i(pop), .head_valid_o(head_valid), .head_o(head)
  );

  // chacha unit
  logic         cc_start, cc_done;
  logic [31:0]  cc_ctr;
  logic [511:0] cc_block;

  chap_chacha u_chacha (
    .clk_i, .rst_ni, .start_i(cc_start), .ctr_i(cc_ctr),
    .key_i({key_q[3], key_q[2], key_q[1], key_q[0]}),
    .nonce_i({nonce_high_q, nonce_low_q}),
    .done_o(cc_done), .block_o(cc_block)
  );

  // poly1305 unit
  chap_pkg::poly_cmd_t  pcmd;
  chap_pkg::poly_stat_t pstat;

  chap_poly u_poly (.clk_i, .rst_ni, .cmd_i(pcmd), .stat_o(pstat));

  // back end state
  chap_pkg::st_e    st_q, st_d;
  chap_pkg::phase_e phase_q, phase_d;
  chap_pkg::citem_t item_q, item_d;
  chap_pkg::res_t   res_q, res_d, out_q, out_d;
  logic        short_q, short_d, out_valid_q, out_valid_d;
  logic [31:0] ctr_q, ctr_d;
  logic [2:0]  idx_q, idx_d;
  logic [511:0] ks_q, ks_d;
  logic [63:0] aad_len_q, aad_len_d, pay_len_q, pay_len_d;
  logic        seq_err, out_free, is_short;
  logic [127:0] ks_chunk, crypt;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_short = item_q.n < 5'd16;
  assign ks_chunk = ks_q[{idx_q[1:0], 7'b0} +: 128];
  assign crypt    = (item_q.dat ^ ks_chunk) & item_q.bmask;

  // ordering check
  always_comb begin
    unique case (item_q.mode)
      chap_pkg::MODE_AAD:
        seq_err = item_q.too_long || phase_q != chap_pkg::PH_AAD || short_q;
      chap_pkg::MODE_PAY:
        seq_err = item_q.too_long || phase_q == chap_pkg::PH_IDLE ||
                  (phase_q == chap_pkg::PH_PAY && short_q);
      chap_pkg::MODE_FINISH:
        seq_err = phase_q != chap_pkg::PH_AAD && phase_q != chap_pkg::PH_PAY;
      default:
        seq_err = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      chap_pkg::ST_IDLE: if (head_valid) st_d = chap_pkg::ST_DECODE;
      chap_pkg::ST_DECODE: begin
        unique case (item_q.mode)
          chap_pkg::MODE_START: st_d = chap_pkg::ST_KEY;
          chap_pkg::MODE_AAD:
            st_d = (seq_err || item_q.empty) ? chap_pkg::ST_RES : chap_pkg::ST_MAC;
          chap_pkg::MODE_PAY: begin
            if (seq_err || item_q.empty) st_d = chap_pkg::ST_RES;
            else if (idx_q[2]) st_d = chap_pkg::ST_KS;
            else st_d = chap_pkg::ST_CRYPT;
          end
          default: st_d = seq_err ? chap_pkg::ST_RES : chap_pkg::ST_MAC;
        endcase
      end
      chap_pkg::ST_KEY:   if (cc_done) st_d = chap_pkg::ST_RES;
      chap_pkg::ST_KS:    if (cc_done) st_d = chap_pkg::ST_CRYPT;
      chap_pkg::ST_CRYPT: st_d = chap_pkg::ST_MAC;
      chap_pkg::ST_MAC: begin
        if (pstat.done) begin
          st_d = (item_q.mode == chap_pkg::MODE_FINISH) ? chap_pkg::ST_TAG
                                                        : chap_pkg::ST_RES;
        end
      end
      chap_pkg::ST_TAG:   if (pstat.done) st_d = chap_pkg::ST_RES;
      chap_pkg::ST_RES:   if (out_free) st_d = chap_pkg::ST_IDLE;
      default:            st_d = chap_pkg::ST_IDLE;
    endcase
  end

  // datapath and unit commands
  always_comb begin
    pop         = 1'b0;
    item_d      = item_q;
    cc_start    = 1'b0;
    cc_ctr      = ctr_q;
    pcmd.start  = 1'b0;
    pcmd.op     = chap_pkg::POLY_BLOCK;
    pcmd.m      = item_q.dat;
    pcmd.s      = cc_block[255:128];
    res_d       = res_q;
    phase_d     = phase_q;
    short_d     = short_q;
    ctr_d       = ctr_q;
    idx_d       = idx_q;
    ks_d        = ks_q;
    aad_len_d   = aad_len_q;
    pay_len_d   = pay_len_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (st_q)
      chap_pkg::ST_IDLE: begin
        if (head_valid) begin
          pop    = 1'b1;
          item_d = head;
        end
      end
      chap_pkg::ST_DECODE: begin
        res_d = '0;
        if (seq_err) begin
          res_d.status = chap_pkg::STAT_SEQ;
        end else begin
          unique case (item_q.mode)
            chap_pkg::MODE_START: begin
              cc_start = 1'b1;
              cc_ctr   = '0;
            end
            chap_pkg::MODE_AAD: begin
              aad_len_d  = aad_len_q + 64'(item_q.n);
              short_d    = short_q || is_short;
              pcmd.start = !item_q.empty;
            end
            chap_pkg::MODE_PAY: begin
              if (phase_q == chap_pkg::PH_AAD) begin
                phase_d = chap_pkg::PH_PAY;
                short_d = is_short;
              end else begin
                short_d = short_q || is_short;
              end
              pay_len_d = pay_len_q + 64'(item_q.n);
              cc_start  = !item_q.empty && idx_q[2];
            end
            default: begin
              pcmd.start = 1'b1;
              pcmd.m     = {pay_len_q, aad_len_q};
            end
          endcase
        end
      end
      chap_pkg::ST_KEY: begin
        if (cc_done) begin
          pcmd.start = 1'b1;
          pcmd.op    = chap_pkg::POLY_CLEAR;
          pcmd.m     = cc_block[127:0];
          phase_d    = chap_pkg::PH_AAD;
          short_d    = 1'b0;
          ctr_d      = 32'd1;
          idx_d      = 3'd4;
          aad_len_d  = '0;
          pay_len_d  = '0;
        end
      end
      chap_pkg::ST_KS: begin
        if (cc_done) begin
          ks_d  = cc_block;
          ctr_d = ctr_q + 32'd1;
          idx_d = 3'd0;
        end
      end
      chap_pkg::ST_CRYPT: begin
        res_d.result_low   = crypt[63:0];
        res_d.result_high  = crypt[127:64];
        res_d.result_count = item_q.n;
        idx_d      = idx_q + 3'd1;
        pcmd.start = 1'b1;
        pcmd.m     = open_q ? item_q.dat : crypt;
      end
      chap_pkg::ST_MAC: begin
        if (pstat.done && item_q.mode == chap_pkg::MODE_FINISH) begin
          pcmd.start = 1'b1;
          pcmd.op    = chap_pkg::POLY_TAG;
        end
      end
      chap_pkg::ST_TAG: begin
        if (pstat.done) begin
          if (open_q) begin
            res_d.status = (pstat.tag == item_q.raw) ? chap_pkg::STAT_OK
                                                     : chap_pkg::STAT_AUTH;
          end else begin
            res_d.result_low   = pstat.tag[63:0];
            res_d.result_high  = pstat.tag[127:64];
            res_d.result_count = 5'd16;
          end
          phase_d = chap_pkg::PH_IDLE;
          short_d = 1'b0;
        end
      end
      chap_pkg::ST_RES: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
    ks_q   <= ks_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= chap_pkg::ST_IDLE;
      phase_q     <= chap_pkg::PH_IDLE;
      short_q     <= 1'b0;
      ctr_q       <= 32'd1;
      idx_q       <= 3'd4;
      aad_len_q   <= '0;
      pay_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      short_q     <= short_d;
      ctr_q       <= ctr_d;
      idx_q       <= idx_d;
      aad_len_q   <= aad_len_d;
      pay_len_q   <= pay_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/chap_front.sv
// input queue that classifies and masks incoming words
module chap_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  chap_pkg::item_t in_data_i,
  input  logic            pop_i,
  output logic            head_valid_o,
  output chap_pkg::citem_t head_o
);

  chap_pkg::citem_t q_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;
  chap_pkg::citem_t cls;
  logic [127:0] m;

  // classify the incoming word
  always_comb begin
    m = chap_pkg::byte_mask(in_data_i.byte_count);
    cls.mode     = in_data_i.mode;
    cls.raw      = {in_data_i.data_high, in_data_i.data_low};
    cls.bmask    = m;
    cls.dat      = {in_data_i.data_high, in_data_i.data_low} & m;
    cls.n        = in_data_i.byte_count;
    cls.too_long = in_data_i.byte_count > 5'd16;
    cls.empty    = in_data_i.byte_count == 5'd0;
  end

  assign in_stall_o   = cnt_q == 2'd2;
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = q_q[rptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop_i) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

>>> rtl/chap_chacha.sv
// iterative chacha20 block function, one half double round per cycle
module chap_chacha (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [31:0]  ctr_i,
  input  logic [255:0] key_i,
  input  logic [95:0]  nonce_i,
  output logic         done_o,
  output logic [511:0] block_o
);

  logic [31:0] x_q [16];
  logic [31:0] in_q [16];
  logic [31:0] init [16];
  logic [31:0] xn [16];
  logic [31:0] xc [16];
  logic [31:0] xd [16];
  logic [4:0]  rnd_q;
  logic        busy_q, done_q;
  logic [511:0] blk_q;

  function automatic logic [127:0] qr(input logic [31:0] a0, input logic [31:0] b0,
                                      input logic [31:0] c0, input logic [31:0] d0);
    logic [31:0] a, b, c, d;
    a = a0; b = b0; c = c0; d = d0;
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    return {a, b, c, d};
  endfunction

  // initial state from key, counter and nonce
  always_comb begin
    init[0] = chap_pkg::SIGMA0;
    init[1] = chap_pkg::SIGMA1;
    init[2] = chap_pkg::SIGMA2;
    init[3] = chap_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) begin
      init[4+i] = key_i[32*i +: 32];
    end
    init[12] = ctr_i;
    init[13] = nonce_i[31:0];
    init[14] = nonce_i[63:32];
    init[15] = nonce_i[95:64];
  end

  // column and diagonal quarter rounds
  always_comb begin
    logic [127:0] rc, rd;
    for (int k = 0; k < 4; k++) begin
      rc = qr(x_q[k], x_q[4+k], x_q[8+k], x_q[12+k]);
      xc[k] = rc[127:96]; xc[4+k] = rc[95:64]; xc[8+k] = rc[63:32]; xc[12+k] = rc[31:0];
      rd = qr(x_q[k], x_q[4+((k+1)&3)], x_q[8+((k+2)&3)], x_q[12+((k+3)&3)]);
      xd[k] = rd[127:96];
      xd[4+((k+1)&3)] = rd[95:64];
      xd[8+((k+2)&3)] = rd[63:32];
      xd[12+((k+3)&3)] = rd[31:0];
    end
    for (int i = 0; i < 16; i++) begin
      xn[i] = rnd_q[0] ? xd[i] : xc[i];
    end
  end

  // working state
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q  <= init;
      in_q <= init;
    end else if (busy_q && rnd_q < 5'd20) begin
      x_q <= xn;
    end
    if (busy_q && rnd_q == 5'd20) begin
      for (int i = 0; i < 16; i++) begin
        blk_q[32*i +: 32] <= x_q[i] + in_q[i];
      end
    end
  end

  // round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= 5'd0;
      end else if (busy_q) begin
        if (rnd_q == 5'd20) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          rnd_q <= rnd_q + 5'd1;
        end
      end
    end
  end

  assign done_o  = done_q;
  assign block_o = blk_q;

endmodule

>>> rtl/chap_poly.sv
// poly1305 unit: key load, 32x32 partial products, fold reduction, final tag
module chap_poly (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  chap_pkg::poly_cmd_t  cmd_i,
  output chap_pkg::poly_stat_t stat_o
);

  chap_pkg::poly_st_e st_q, st_d;
  logic [127:0] r_q, s_q, tag_q;
  logic [130:0] h_q, t_q;
  logic [159:0] a_q;
  logic [255:0] acc_q;
  logic [63:0]  p_q;
  logic         pv_q, done_q;
  logic [2:0]   sh_q, i_q;
  logic [1:0]   j_q;
  logic         last;
  logic [255:0] acc_add;
  logic [130:0] fold_acc, fold_t, fold_h;
  logic [130:0] g5;

  assign last = i_q == 3'd4 && j_q == 2'd3;

  // datapath helpers
  always_comb begin
    acc_add  = acc_q + (256'(p_q) << {sh_q, 5'b0});
    fold_acc = 131'(acc_q[129:0]) + 131'({acc_q[255:130], 2'b00}) + 131'(acc_q[255:130]);
    fold_t   = 131'(t_q[129:0]) + 131'({t_q[130], 2'b00}) + 131'(t_q[130]);
    fold_h   = 131'(h_q[129:0]) + 131'({h_q[130], 2'b00}) + 131'(h_q[130]);
    g5       = 131'(t_q[129:0]) + 131'(5);
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      chap_pkg::PS_IDLE: begin
        if (cmd_i.start && cmd_i.op == chap_pkg::POLY_BLOCK) st_d = chap_pkg::PS_MUL;
        else if (cmd_i.start && cmd_i.op == chap_pkg::POLY_TAG) st_d = chap_pkg::PS_TAG2;
      end
      chap_pkg::PS_MUL:  if (last) st_d = chap_pkg::PS_ADD;
      chap_pkg::PS_ADD:  st_d = chap_pkg::PS_RED1;
      chap_pkg::PS_RED1: st_d = chap_pkg::PS_RED2;
      chap_pkg::PS_RED2: st_d = chap_pkg::PS_IDLE;
      chap_pkg::PS_TAG2: st_d = chap_pkg::PS_TAG3;
      chap_pkg::PS_TAG3: st_d = chap_pkg::PS_TAG4;
      chap_pkg::PS_TAG4: st_d = chap_pkg::PS_IDLE;
      default:           st_d = chap_pkg::PS_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      chap_pkg::PS_IDLE: begin
        if (cmd_i.start) begin
          unique case (cmd_i.op)
            chap_pkg::POLY_CLEAR: begin
              r_q <= cmd_i.m & chap_pkg::CLAMP;
              s_q <= cmd_i.s;
              h_q <= '0;
            end
            chap_pkg::POLY_BLOCK: begin
              a_q   <= 160'({1'b0, h_q} + {4'b0001, cmd_i.m});
              acc_q <= '0;
              i_q   <= 3'd0;
              j_q   <= 2'd0;
            end
            chap_pkg::POLY_TAG: t_q <= fold_h;
            default: ;
          endcase
        end
      end
      chap_pkg::PS_MUL: begin
        p_q  <= a_q[32*i_q +: 32] * r_q[32*j_q +: 32];
        sh_q <= i_q + 3'(j_q);
        if (pv_q) acc_q <= acc_add;
        j_q <= j_q + 2'd1;
        if (j_q == 2'd3) i_q <= i_q + 3'd1;
      end
      chap_pkg::PS_ADD:  acc_q <= acc_add;
      chap_pkg::PS_RED1: t_q <= fold_acc;
      chap_pkg::PS_RED2: h_q <= fold_t;
      chap_pkg::PS_TAG2: t_q <= fold_t;
      chap_pkg::PS_TAG3: if (g5[130]) t_q <= {1'b0, g5[129:0]};
      chap_pkg::PS_TAG4: tag_q <= t_q[127:0] + s_q;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= chap_pkg::PS_IDLE;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pv_q   <= st_q == chap_pkg::PS_MUL;
      done_q <= st_q == chap_pkg::PS_RED2 || st_q == chap_pkg::PS_TAG4;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.tag  = tag_q;

endmodule

>>> dv/testbench.sv
// self-checking testbench of the chacha20-poly1305 aead core
`timescale 1ns / 1ps

module testbench;
  import chap_pkg::*;

  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 150;
  localparam logic [263:0] POLY_P = (264'd1 << 130) - 264'd5;

  // directed stimulus row; typed rows carry a zero payload and a fixed status
  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] dl;
    logic [63:0] dh;
    logic [4:0]  n;
    logic        typed;
    logic [1:0]  st;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  item_t in_data_i;
  res_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;

  // register copies
  logic [63:0] key_q [4];
  logic [63:0] nonce_lo_q;
  logic [31:0] nonce_hi_q;
  logic        open_q;

  // message state
  logic [31:0]  blk_ctr;
  logic [511:0] ks_blk;
  int           ks_idx;
  logic [127:0] poly_r, poly_s;
  logic [129:0] poly_acc;
  logic [63:0]  aad_len, pay_len;
  phase_e       msg_phase;
  logic         short_seen;

  res_t result_q [$];
  int   errors, words_sent, words_back, messages;
  bit   sender_idle_on, recv_idle_on, hold_done;

  chacha20_poly1305_aead_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // clock
  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int k);
    return (v << k) | (v >> (32 - k));
  endfunction

  // one chacha20 block for the current key and nonce, word i at bits 32*i
  function automatic logic [511:0] chacha_block(input logic [31:0] ctr);
    logic [31:0] st [16];
    logic [31:0] x [16];
    logic [511:0] o;
    int q [8][4];
    int a, b, c, d;
    q = '{'{0,4,8,12}, '{1,5,9,13}, '{2,6,10,14}, '{3,7,11,15},
          '{0,5,10,15}, '{1,6,11,12}, '{2,7,8,13}, '{3,4,9,14}};
    st[0] = SIGMA0; st[1] = SIGMA1; st[2] = SIGMA2; st[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      st[4+2*i] = key_q[i][31:0];
      st[5+2*i] = key_q[i][63:32];
    end
    st[12] = ctr;
    st[13] = nonce_lo_q[31:0];
    st[14] = nonce_lo_q[63:32];
    st[15] = nonce_hi_q;
    x = st;
    for (int rd = 0; rd < 10; rd++) begin
      for (int k = 0; k < 8; k++) begin
        a = q[k][0]; b = q[k][1]; c = q[k][2]; d = q[k][3];
        x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 7);
      end
    end
    for (int i = 0; i < 16; i++) o[32*i +: 32] = x[i] + st[i];
    return o;
  endfunction

  // one poly1305 block with the 2^128 pad bit, fully reduced mod 2^130-5
  function automatic logic [129:0] poly_absorb(input logic [129:0] acc,
                                               input logic [127:0] blk);
    logic [263:0] x;
    x = (264'(acc) + {136'd1, blk}) * 264'(poly_r);
    while ((x >> 130) != 0) x = 264'(x[129:0]) + (x >> 130) * 264'd5;
    if (x >= POLY_P) x = x - POLY_P;
    return x[129:0];
  endfunction

  // tag that a finish would produce now
  function automatic logic [127:0] tag_now();
    logic [129:0] h;
    h = poly_absorb(poly_acc, {pay_len, aad_len});
    return h[127:0] + poly_s;
  endfunction

  function automatic logic [127:0] chunk_mask(input logic [4:0] n);
    logic [128:0] m;
    m = (129'd1 << (8 * n)) - 129'd1;
    return m[127:0];
  endfunction

  // advance the message state by one word and give its result
  task automatic aead_step(input item_t it, output res_t r);
    logic [127:0] m, dat, ct, tg;
    logic [511:0] b0;
    m = chunk_mask(it.byte_count);
    dat = {it.data_high, it.data_low} & m;
    r = '0;
    case (it.mode)
      MODE_START: begin
        b0 = chacha_block(32'd0);
        poly_r = b0[127:0] & CLAMP;
        poly_s = b0[255:128];
        poly_acc = '0;
        blk_ctr = 32'd1;
        ks_idx = 4;
        aad_len = '0;
        pay_len = '0;
        msg_phase = PH_AAD;
        short_seen = 1'b0;
      end
      MODE_AAD: begin
        if (it.byte_count > 16 || msg_phase != PH_AAD || short_seen) begin
          r.status = STAT_SEQ;
        end else begin
          if (it.byte_count != 0) poly_acc = poly_absorb(poly_acc, dat);
          aad_len += 64'(it.byte_count);
          if (it.byte_count < 16) short_seen = 1'b1;
        end
      end
      MODE_PAY: begin
        if (it.byte_count > 16 || msg_phase == PH_IDLE ||
            (msg_phase == PH_PAY && short_seen)) begin
          r.status = STAT_SEQ;
        end else begin
          if (msg_phase == PH_AAD) begin
            msg_phase = PH_PAY;
            short_seen = 1'b0;
          end
          if (it.byte_count != 0) begin
            if (ks_idx >= 4) begin
              ks_blk = chacha_block(blk_ctr);
              blk_ctr++;
              ks_idx = 0;
            end
            ct = (dat ^ ks_blk[128*ks_idx +: 128]) & m;
            ks_idx++;
            poly_acc = poly_absorb(poly_acc, open_q ? dat : ct);
            r.result_low = ct[63:0];
            r.result_high = ct[127:64];
            r.result_count = it.byte_count;
          end
          pay_len += 64'(it.byte_count);
          if (it.byte_count < 16) short_seen = 1'b1;
        end
      end
      default: begin
        if (msg_phase == PH_IDLE) begin
          r.status = STAT_SEQ;
        end else begin
          tg = tag_now();
          if (open_q) begin
            r.status = (tg == {it.data_high, it.data_low}) ? STAT_OK : STAT_AUTH;
          end else begin
            r.result_low = tg[63:0];
            r.result_high = tg[127:64];
            r.result_count = 5'd16;
          end
          msg_phase = PH_IDLE;
          short_seen = 1'b0;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch at %0t on %s: got %h, want %h", $time, what, got, want);
  endtask

  // apb write, setup then access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_KEY0: key_q[0] = val;
      REG_KEY1: key_q[1] = val;
      REG_KEY2: key_q[2] = val;
      REG_KEY3: key_q[3] = val;
      REG_NONCE_L: nonce_lo_q = val;
      REG_NONCE_H: nonce_hi_q = val[31:0];
      default: open_q = val[0];
    endcase
  endtask

  // offer one word after a random gap, return once it is taken
  task automatic send_word(input item_t it);
    int gap;
    gap = sender_idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  // predict, queue the expectation, send
  task automatic issue(input item_t it, input bit typed, input res_t fixed);
    res_t r;
    aead_step(it, r);
    result_q.push_back(typed ? fixed : r);
    send_word(it);
  endtask

  task automatic issue_pred(input item_t it);
    issue(it, 1'b0, '0);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic item_t chunk(input logic [1:0] md, input logic [4:0] n);
    item_t it;
    it.mode = md;
    it.data_low = rand64();
    it.data_high = rand64();
    it.byte_count = n;
    return it;
  endfunction

  // well-formed message with random content, sometimes broken
  task automatic random_message();
    item_t it;
    logic [127:0] tg;
    int n_aad, n_pay;
    n_aad = $urandom_range(0, 3);
    n_pay = $urandom_range(0, 9);
    issue_pred(chunk(MODE_START, 5'd0));
    messages++;
    for (int i = 0; i < n_aad; i++) issue_pred(chunk(MODE_AAD, 5'd16));
    if ($urandom_range(0, 1)) issue_pred(chunk(MODE_AAD, 5'($urandom_range(0, 15))));
    for (int i = 0; i < n_pay; i++) issue_pred(chunk(MODE_PAY, 5'd16));
    if ($urandom_range(0, 1)) issue_pred(chunk(MODE_PAY, 5'($urandom_range(0, 15))));
    // broken sequence now and then
    if ($urandom_range(0, 7) == 0) begin
      issue_pred(chunk(2'($urandom_range(1, 2)), 5'($urandom_range(0, 31))));
    end
    it = chunk(MODE_FINISH, 5'($urandom_range(0, 31)));
    if (open_q && $urandom_range(0, 3) != 0) begin
      tg = tag_now();
      it.data_low = tg[63:0];
      it.data_high = tg[127:64];
    end else if (open_q && $urandom_range(0, 1)) begin
      tg = tag_now() ^ (128'd1 << $urandom_range(0, 127));
      it.data_low = tg[63:0];
      it.data_high = tg[127:64];
    end
    issue_pred(it);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // receiver: random stall per word, one long hold-off, field checks
  initial begin
    res_t want;
    int n;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      n = recv_idle_on ? $urandom_range(0, 6) : 0;
      if (!hold_done && words_back == 150) begin
        n = LONG_HOLD;
        hold_done = 1'b1;
      end
      @(negedge clk_i);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      words_back++;
      if (result_q.size() == 0) begin
        errors++;
        $display("result at %0t with nothing expected", $time);
      end else begin
        want = result_q.pop_front();
        if (out_data_o.result_low !== want.result_low)
          report_mismatch("result_low", out_data_o.result_low, want.result_low);
        if (out_data_o.result_high !== want.result_high)
          report_mismatch("result_high", out_data_o.result_high, want.result_high);
        if (out_data_o.result_count !== want.result_count)
          report_mismatch("result_count", 64'(out_data_o.result_count),
                          64'(want.result_count));
        if (out_data_o.status !== want.status)
          report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
      end
    end
  end

  // run limit
  initial begin
    #4ms;
    $display("timeout with %0d words outstanding", result_q.size());
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    dir_row_t dir_tab [26];
    item_t it;
    res_t fixed;
    logic [2:0] idx;
    dir_tab = '{
      '{MODE_FINISH, ONES, ONES, 5'd16, 1'b1, STAT_SEQ},
      '{MODE_AAD,    ONES, ONES, 5'd16, 1'b1, STAT_SEQ},
      '{MODE_PAY,    ONES, ONES, 5'd16, 1'b1, STAT_SEQ},
      '{MODE_START,  ONES, ONES, 5'd31, 1'b1, STAT_OK},
      '{MODE_AAD,    ONES, ONES, 5'd17, 1'b1, STAT_SEQ},
      '{MODE_AAD,    ONES, ONES, 5'd31, 1'b1, STAT_SEQ},
      '{MODE_AAD,    ONES, ONES, 5'd16, 1'b1, STAT_OK},
      '{MODE_AAD,    ONES, ONES, 5'd0,  1'b1, STAT_OK},
      '{MODE_AAD,    ONES, ONES, 5'd16, 1'b1, STAT_SEQ},
      '{MODE_PAY,    ONES, ONES, 5'd16, 1'b0, STAT_OK},
      '{MODE_PAY,    ONES, ONES, 5'd0,  1'b1, STAT_OK},
      '{MODE_PAY,    ONES, ONES, 5'd8,  1'b1, STAT_SEQ},
      '{MODE_AAD,    ONES, ONES, 5'd8,  1'b1, STAT_SEQ},
      '{MODE_FINISH, 64'd0, 64'd0, 5'd0, 1'b0, STAT_OK},
      '{MODE_FINISH, 64'd0, 64'd0, 5'd16, 1'b1, STAT_SEQ},
      '{MODE_START,  64'd0, 64'd0, 5'd0, 1'b1, STAT_OK},
      '{MODE_PAY,    ONES, ONES, 5'd1,  1'b0, STAT_OK},
      '{MODE_FINISH, ONES, ONES, 5'd16, 1'b0, STAT_OK},
      '{MODE_START,  64'd0, 64'd0, 5'd0, 1'b1, STAT_OK},
      '{MODE_FINISH, 64'd0, 64'd0, 5'd0, 1'b0, STAT_OK},
      '{MODE_START,  64'd0, 64'd0, 5'd0, 1'b1, STAT_OK},
      '{MODE_AAD,    ONES, 64'h0123_4567_89ab_cdef, 5'd9, 1'b0, STAT_OK},
      '{MODE_PAY,    64'd0, 64'd0, 5'd15, 1'b0, STAT_OK},
      '{MODE_START,  ONES, 64'd0, 5'd16, 1'b1, STAT_OK},
      '{MODE_PAY,    64'd0, 64'd0, 5'd16, 1'b0, STAT_OK},
      '{MODE_FINISH, 64'd0, 64'd0, 5'd0, 1'b0, STAT_OK}
    };
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; words_sent = 0; words_back = 0; messages = 0;
    hold_done = 1'b0;
    sender_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    key_q = '{64'd0, 64'd0, 64'd0, 64'd0};
    nonce_lo_q = '0; nonce_hi_q = '0; open_q = 1'b0;
    blk_ctr = 32'd1; ks_blk = '0; ks_idx = 4;
    poly_r = '0; poly_s = '0; poly_acc = '0;
    aad_len = '0; pay_len = '0;
    msg_phase = PH_IDLE; short_seen = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part on reset register values
    foreach (dir_tab[i]) begin
      it.mode = dir_tab[i].mode;
      it.data_low = dir_tab[i].dl;
      it.data_high = dir_tab[i].dh;
      it.byte_count = dir_tab[i].n;
      fixed = '0;
      fixed.status = dir_tab[i].st;
      issue(it, dir_tab[i].typed, fixed);
    end
    wait_drained();

    // random part over several register settings
    for (int p = 0; p < 6; p++) begin
      for (int r = 0; r < 7; r++) begin
        idx = 3'(r);
        case (p)
          2: reg_write(idx, (idx == REG_OPEN) ? 64'd1 : ONES);
          3: reg_write(idx, 64'd0);
          default: reg_write(idx, (idx == REG_OPEN) ? 64'(p % 2) : rand64());
        endcase
      end
      sender_idle_on = (p != 4);
      recv_idle_on = (p != 3);
      while (words_sent < 26 + 105 * (p + 1)) begin
        if ($urandom_range(0, 9) == 0) begin
          issue_pred(chunk(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31))));
        end else begin
          random_message();
        end
      end
      wait_drained();
    end

    $display("sent %0d words in %0d random messages over 7 register settings,",
             words_sent, messages);
    $display("seal and open, with sequence errors and a long output hold-off");
    if (errors == 0 && result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/chap_pkg.sv
rtl/chap_front.sv
rtl/chap_chacha.sv
rtl/chap_poly.sv
rtl/chacha20_poly1305_aead_core.sv
dv/testbench.sv
